FILE: hw/rtl/hmwp_pkg.sv
// Shared constants for the height map window pooling block.
// Field widths, register indexes, reset values and mode codes.
// No dependencies.
package hmwp_pkg;

    // Input and result field widths
    localparam int COORD_W      = 5;
    localparam int IN_HEIGHT_W  = 8;
    localparam int OUT_HEIGHT_W = 8;
    localparam int AVG_W        = 16;

    // Configuration registers
    localparam int STRIDE_W   = 6;
    localparam int WSIZE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 6'd2;
    localparam logic [WSIZE_W-1:0]  WSIZE_RESET  = 4'd2;

    // Request modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Window corner arithmetic: coordinate times stride, plus window size
    localparam int CORNER_W = COORD_W + STRIDE_W;
    localparam int EDGE_W   = CORNER_W + 1;

endpackage

FILE: hw/rtl/height_map_window_pooling.sv
// Top level of the height map window pooling block.
// Height memory, scan sequencer, restoring divider, output register.
// Depends on hmwp_pkg.

// Keeps a GRID_WIDTH x GRID_LENGTH map of cell heights. After reset a clearing
// pass zeroes the memory one cell per cycle; in_stall is high during it, and
// configuration writes are taken throughout. A write request gives no result.
// For a query the memory read port delivers one cell per cycle to the
// max/min/sum accumulator, and the mean then goes through a one-bit-per-cycle
// divider of HEIGHT_BITS + 16 steps. A rejected window goes from the check
// straight to the result, with no scan and no division. One request is worked
// on at a time; a new request is taken while the last result still waits in
// the output register.
module height_map_window_pooling #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_LENGTH = 32,
    parameter int HEIGHT_BITS = 8,
    parameter int MAX_WINDOW  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hmwp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hmwp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [hmwp_pkg::COORD_W-1:0]        row,
    input  logic [hmwp_pkg::COORD_W-1:0]        col,
    input  logic [hmwp_pkg::IN_HEIGHT_W-1:0]    height,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hmwp_pkg::OUT_HEIGHT_W-1:0]   peak_height,
    output logic [hmwp_pkg::OUT_HEIGHT_W-1:0]   min_height,
    output logic [hmwp_pkg::AVG_W-1:0]          avg_height_fx,
    output logic                                status
);
    import hmwp_pkg::*;

    // Memory geometry
    localparam int RB     = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int CB     = (GRID_LENGTH > 1) ? $clog2(GRID_LENGTH) : 1;
    localparam int ADDR_W = RB + CB;
    localparam int DEPTH  = 1 << ADDR_W;

    // Accumulator and divider widths (at most 15 x 15 cells summed)
    localparam int SUM_W  = HEIGHT_BITS + 8;
    localparam int NUM_W  = SUM_W + 8;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int AREA_W = 8;
    localparam int EXT_W  = (HEIGHT_BITS > OUT_HEIGHT_W) ? HEIGHT_BITS : OUT_HEIGHT_W;

    localparam logic [EDGE_W-1:0]  GW_LIM   = EDGE_W'(GRID_WIDTH);
    localparam logic [EDGE_W-1:0]  GL_LIM   = EDGE_W'(GRID_LENGTH);
    localparam logic [WSIZE_W:0]   MAXW_LIM = (WSIZE_W + 1)'(MAX_WINDOW);
    localparam logic [8:0]         GW_IN    = 9'(GRID_WIDTH);
    localparam logic [8:0]         GL_IN    = 9'(GRID_LENGTH);
    localparam logic [HEIGHT_BITS-1:0] HMASK = {HEIGHT_BITS{1'b1}};
    localparam logic [EXT_W-1:0]   OUT_TOP  = EXT_W'({OUT_HEIGHT_W{1'b1}});

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [STRIDE_W-1:0]     stride_reg;
    logic [WSIZE_W-1:0]      wsize_reg;
    logic [COORD_W-1:0]      qrow_reg;
    logic [COORD_W-1:0]      qcol_reg;
    logic                    reject_reg;
    logic [RB-1:0]           r_cur_reg;
    logic [CB-1:0]           c_cur_reg;
    logic [CB-1:0]           c_base_reg;
    logic [WSIZE_W-1:0]      ri_reg;
    logic [WSIZE_W-1:0]      ci_reg;
    logic                    rd_valid_reg;
    logic [HEIGHT_BITS-1:0]  rd_data_reg;
    logic [HEIGHT_BITS-1:0]  mx_reg;
    logic [HEIGHT_BITS-1:0]  mn_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [NUM_W-1:0]        quot_reg;
    logic [AREA_W-1:0]       rem_reg;
    logic [AREA_W-1:0]       div_reg;
    logic [CNT_W-1:0]        div_cnt_reg;
    logic                    out_valid_reg;
    logic [OUT_HEIGHT_W-1:0] max_reg;
    logic [OUT_HEIGHT_W-1:0] min_reg;
    logic [AVG_W-1:0]        avg_reg;
    logic                    status_reg;

    logic [HEIGHT_BITS-1:0]  mem [DEPTH];

    // Handshakes
    logic in_acc;
    logic out_take;
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // Write request decode
    logic in_grid;
    assign in_grid = ({4'b0, row} < GW_IN) && ({4'b0, col} < GL_IN);

    // Memory port control
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [HEIGHT_BITS-1:0] mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = in_acc && (mode == MODE_WRITE) && in_grid;
            mem_waddr = {RB'(row), CB'(col)};
            mem_wdata = HEIGHT_BITS'(height);
        end
    end

    assign mem_re    = (state_reg == ST_SCAN);
    assign mem_raddr = {r_cur_reg, c_cur_reg};

    // Height memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Window corner and rejection check
    logic [CORNER_W-1:0] r0;
    logic [CORNER_W-1:0] c0;
    logic                bad_window;
    assign r0 = CORNER_W'(qrow_reg) * CORNER_W'(stride_reg);
    assign c0 = CORNER_W'(qcol_reg) * CORNER_W'(stride_reg);
    assign bad_window = (wsize_reg == '0)
                     || ({1'b0, wsize_reg} > MAXW_LIM)
                     || (({1'b0, r0} + EDGE_W'(wsize_reg)) > GW_LIM)
                     || (({1'b0, c0} + EDGE_W'(wsize_reg)) > GL_LIM);

    // Scan counters
    logic [WSIZE_W-1:0] w_last;
    logic               col_last;
    logic               row_last;
    assign w_last   = wsize_reg - 1'b1;
    assign col_last = (ci_reg == w_last);
    assign row_last = (ri_reg == w_last);

    // Restoring divider step
    logic [AREA_W:0]   trial;
    logic              q_bit;
    logic [AREA_W-1:0] rem_step;
    assign trial    = {rem_reg, quot_reg[NUM_W-1]};
    assign q_bit    = (trial >= {1'b0, div_reg});
    assign rem_step = q_bit ? AREA_W'(trial - {1'b0, div_reg}) : AREA_W'(trial);

    // Result saturation
    logic [EXT_W-1:0] mx_ext;
    logic [EXT_W-1:0] mn_ext;
    logic             avg_over;
    assign mx_ext   = EXT_W'(mx_reg);
    assign mn_ext   = EXT_W'(mn_reg);
    assign avg_over = (quot_reg[NUM_W-1:AVG_W] != '0);

    // Sequencer, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            stride_reg    <= STRIDE_RESET;
            wsize_reg     <= WSIZE_RESET;
            qrow_reg      <= '0;
            qcol_reg      <= '0;
            reject_reg    <= 1'b0;
            r_cur_reg     <= '0;
            c_cur_reg     <= '0;
            c_base_reg    <= '0;
            ri_reg        <= '0;
            ci_reg        <= '0;
            rd_valid_reg  <= 1'b0;
            mx_reg        <= '0;
            mn_reg        <= '0;
            sum_reg       <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
            min_reg       <= '0;
            avg_reg       <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_STRIDE)
                begin
                    stride_reg <= cfg_data[STRIDE_W-1:0];
                end
                else if (cfg_index == REG_WINDOW_SIZE)
                begin
                    wsize_reg <= cfg_data[WSIZE_W-1:0];
                end
            end

            // result handed over; in ST_FINISH the next result takes its place
            if (out_take && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            // accumulate the cell read in the previous cycle
            rd_valid_reg <= (state_reg == ST_SCAN);
            if (rd_valid_reg)
            begin
                if (rd_data_reg > mx_reg)
                begin
                    mx_reg <= rd_data_reg;
                end
                if (rd_data_reg < mn_reg)
                begin
                    mn_reg <= rd_data_reg;
                end
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_acc && (mode == MODE_QUERY))
                    begin
                        qrow_reg  <= row;
                        qcol_reg  <= col;
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    reject_reg <= bad_window;
                    r_cur_reg  <= RB'(r0);
                    c_cur_reg  <= CB'(c0);
                    c_base_reg <= CB'(c0);
                    ri_reg     <= '0;
                    ci_reg     <= '0;
                    mx_reg     <= '0;
                    mn_reg     <= HMASK;
                    sum_reg    <= '0;
                    state_reg  <= bad_window ? ST_FINISH : ST_SCAN;
                end

                ST_SCAN:
                begin
                    if (col_last)
                    begin
                        ci_reg    <= '0;
                        c_cur_reg <= c_base_reg;
                        ri_reg    <= ri_reg + 1'b1;
                        r_cur_reg <= r_cur_reg + 1'b1;
                        if (row_last)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        ci_reg    <= ci_reg + 1'b1;
                        c_cur_reg <= c_cur_reg + 1'b1;
                    end
                end

                ST_DRAIN:
                begin
                    state_reg <= ST_LOAD;
                end

                ST_LOAD:
                begin
                    quot_reg    <= {sum_reg, 8'b0};
                    rem_reg     <= '0;
                    div_reg     <= AREA_W'(wsize_reg) * AREA_W'(wsize_reg);
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end

                ST_DIV:
                begin
                    quot_reg    <= {quot_reg[NUM_W-2:0], q_bit};
                    rem_reg     <= rem_step;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= reject_reg;
                        if (reject_reg)
                        begin
                            max_reg <= '0;
                            min_reg <= '0;
                            avg_reg <= '0;
                        end
                        else
                        begin
                            max_reg <= (mx_ext > OUT_TOP) ? '1 : OUT_HEIGHT_W'(mx_ext);
                            min_reg <= (mn_ext > OUT_TOP) ? '1 : OUT_HEIGHT_W'(mn_ext);
                            avg_reg <= avg_over ? '1 : AVG_W'(quot_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign peak_height   = max_reg;
    assign min_height    = min_reg;
    assign avg_height_fx = avg_reg;
    assign status        = status_reg;

    // A rejected window carries all-zero result fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |->
            (max_reg == '0 && min_reg == '0 && avg_reg == '0))
        else $error("rejected window with nonzero result fields");

    // A good window never reports a minimum above its maximum
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !status_reg) |-> (min_reg <= max_reg))
        else $error("window minimum above maximum");

    // No result can appear while the memory is still being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!out_valid_reg && !rd_valid_reg))
        else $error("activity during clearing pass");

    // Read data only returns right after a scan cycle
    a_read_timing: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("read data outside window scan");

    // A pending result keeps its valid flag, average and status while the consumer stalls
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(avg_reg)
            && $stable(status_reg)))
        else $error("stalled result changed");

endmodule
